// ===== src/lcf_pkg.sv =====
// Shared constants and types of the CR LF response line framer.
`timescale 1ns / 1ps
`default_nettype none
package lcf_pkg;

    // Buffer size: at most LINE_MAX-1 bytes are held.
    localparam int LINE_MAX = 64;
    localparam int LEN_W    = $clog2(LINE_MAX);
    localparam int BYTE_W   = 8;

    // Highest line length; a store is refused at this length.
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX - 1);

    // Characters with a meaning of their own.
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_R  = 8'h52;
    localparam logic [BYTE_W-1:0] CH_D  = 8'h44;
    localparam logic [BYTE_W-1:0] CH_Y  = 8'h59;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              last_of_line;
        logic              status;
    } out_item_t;

endpackage
`default_nettype wire

// ===== src/crlf_response_line_framer_top.sv =====
// Top level of the CR LF response line framer: sequencer around the line RAM.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one received byte per slave word and collects response lines
// in a line RAM until CR LF ends them. A byte after a pending CR also stores the
// held CR, since the CR and the byte are written one after the other through the
// single RAM write port. A completed line is read back and sent byte by byte: each
// byte is read from the RAM, then pushed into the output register once that
// register can take a word; "RDY" lines are dropped silently. Bytes that do
// not fit are dropped and reported by one status word with tuser set. The slave
// side is held only while the sequencer is busy; a result word may wait in the
// output register while the next byte is taken.
module crlf_response_line_framer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] line_byte
    output logic            m_tlast,   // last_of_line
    output logic            m_tuser    // [0] status
);

    localparam int LEN_W = lcf_pkg::LEN_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_STORE_B = 3'd1;
    localparam logic [2:0] ST_STATUS  = 3'd2;
    localparam logic [2:0] ST_RD      = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             cr_pend_reg, cr_pend_next;
    logic             rdy_reg, rdy_next;
    logic             drop_reg, drop_next;
    logic [7:0]       byte_reg, byte_next;

    logic             store_en;
    logic [7:0]       store_data;
    logic             store_ok;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic             push;
    lcf_pkg::out_item_t push_item;
    logic             can_push;
    logic             accept;
    logic             last_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign store_ok = (len_reg < lcf_pkg::LEN_LIMIT);
    assign last_idx = (idx_reg == len_reg - LEN_W'(1));

    // Sequencer: decode the byte, write the RAM, read a line back.
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        cr_pend_next = cr_pend_reg;
        drop_next    = drop_reg;
        byte_next    = byte_reg;
        store_en     = 1'b0;
        store_data   = s_tdata;
        rd_en        = 1'b0;
        push         = 1'b0;
        push_item    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tdata == lcf_pkg::CH_CR) begin
                        cr_pend_next = 1'b1;
                    end else if (s_tdata == lcf_pkg::CH_LF && cr_pend_reg) begin
                        cr_pend_next = 1'b0;
                        idx_next     = '0;
                        if (len_reg != '0) begin
                            if (len_reg == LEN_W'(3) && rdy_reg) begin
                                len_next = '0;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                    end else if (cr_pend_reg) begin
                        // Store the held CR now and the byte next cycle.
                        cr_pend_next = 1'b0;
                        store_en     = 1'b1;
                        store_data   = lcf_pkg::CH_CR;
                        drop_next    = !store_ok;
                        byte_next    = s_tdata;
                        state_next   = ST_STORE_B;
                    end else begin
                        store_en   = 1'b1;
                        store_data = s_tdata;
                        drop_next  = !store_ok;
                        state_next = store_ok ? ST_IDLE : ST_STATUS;
                    end
                end
            end
            ST_STORE_B: begin
                store_en   = 1'b1;
                store_data = byte_reg;
                drop_next  = drop_reg || !store_ok;
                state_next = (drop_reg || !store_ok) ? ST_STATUS : ST_IDLE;
            end
            ST_STATUS: begin
                push_item.line_byte    = '0;
                push_item.last_of_line = 1'b1;
                push_item.status       = 1'b1;
                if (can_push) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                push_item.line_byte    = rd_data;
                push_item.last_of_line = last_idx;
                push_item.status       = 1'b0;
                if (can_push) begin
                    push = 1'b1;
                    if (last_idx) begin
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A store that fits lands at the current length.
        if (store_en && store_ok) begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    // Track whether the first three stored bytes spell RDY.
    always_comb begin
        rdy_next = rdy_reg;
        if (store_en && store_ok) begin
            if (len_reg == LEN_W'(0)) begin
                rdy_next = (store_data == lcf_pkg::CH_R);
            end else if (len_reg == LEN_W'(1)) begin
                rdy_next = rdy_reg && (store_data == lcf_pkg::CH_D);
            end else if (len_reg == LEN_W'(2)) begin
                rdy_next = rdy_reg && (store_data == lcf_pkg::CH_Y);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cr_pend_reg <= 1'b0;
            rdy_reg     <= 1'b0;
            drop_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cr_pend_reg <= cr_pend_next;
            rdy_reg     <= rdy_next;
            drop_reg    <= drop_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // Line storage.
    lcf_ram #(
        .DEPTH (lcf_pkg::LINE_MAX),
        .WIDTH (lcf_pkg::BYTE_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (store_en && store_ok),
        .wr_addr (len_reg),
        .wr_data (store_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Result register toward the master side.
    lcf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .can_push  (can_push),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

// ===== src/lcf_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lcf_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== src/lcf_out_buf.sv =====
// Output register that holds one result word for the master side.
`timescale 1ns / 1ps
`default_nettype none
module lcf_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire lcf_pkg::out_item_t push_item,
    output logic                   can_push,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic               valid_reg;
    logic               valid_next;
    lcf_pkg::out_item_t item_reg;

    // A new word may enter when the register is empty or being drained.
    assign can_push   = !valid_reg || m_tready;
    assign valid_next = push ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= push_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.line_byte;
    assign m_tlast  = item_reg.last_of_line;
    assign m_tuser  = item_reg.status;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the CR LF response line framer: directed rows, then random lines.
`timescale 1ns / 1ps
module tb_top;
    import lcf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 285;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int N_ROWS       = 28;

    // How the directed rows are checked: by the line model, by the fixed overflow word, or as rows that book no word.
    typedef enum logic [1:0] {
        ROW_CALC,
        ROW_QUIET,
        ROW_DROP
    } row_kind_e;

    typedef struct packed {
        logic [7:0] rx;
        logic [6:0] reps;
        row_kind_e  kind;
    } dir_row_t;

    localparam out_item_t OVERFLOW_WORD = '{8'h00, 1'b1, 1'b1};

    // Directed rows: extremes, line endings, the RDY drop and the buffer overflow.
    localparam dir_row_t DIR_ROWS [N_ROWS] = '{
        '{8'h00, 7'd1, ROW_QUIET},
        '{8'hFF, 7'd1, ROW_QUIET},
        '{CH_CR, 7'd1, ROW_QUIET},
        '{CH_LF, 7'd1, ROW_CALC},
        '{CH_CR, 7'd1, ROW_QUIET},
        '{CH_LF, 7'd1, ROW_QUIET},
        '{CH_LF, 7'd1, ROW_QUIET},
        '{8'h61, 7'd1, ROW_QUIET},
        '{CH_CR, 7'd2, ROW_QUIET},
        '{8'h62, 7'd1, ROW_QUIET},
        '{CH_CR, 7'd1, ROW_QUIET},
        '{CH_LF, 7'd1, ROW_CALC},
        '{CH_R,  7'd1, ROW_QUIET},
        '{CH_D,  7'd1, ROW_QUIET},
        '{CH_Y,  7'd1, ROW_QUIET},
        '{CH_CR, 7'd1, ROW_QUIET},
        '{CH_LF, 7'd1, ROW_QUIET},
        '{CH_R,  7'd1, ROW_QUIET},
        '{CH_D,  7'd1, ROW_QUIET},
        '{CH_Y,  7'd1, ROW_QUIET},
        '{8'h00, 7'd1, ROW_QUIET},
        '{CH_CR, 7'd1, ROW_QUIET},
        '{CH_LF, 7'd1, ROW_CALC},
        '{8'h41, 7'd63, ROW_QUIET},
        '{8'h42, 7'd1, ROW_DROP},
        '{CH_CR, 7'd1, ROW_QUIET},
        '{8'h43, 7'd1, ROW_DROP},
        '{CH_LF, 7'd1, ROW_CALC}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Line model state.
    logic [7:0]       held_bytes [LINE_MAX];
    logic [LEN_W-1:0] held_len;
    bit               cr_seen;
    out_item_t        step_words [$];

    out_item_t line_words_due [$];
    int        mismatches  = 0;
    int        words_seen  = 0;
    int        cycle_count = 0;
    int        sent_random = 0;
    bit        tx_quiet    = 1'b0;
    bit        rx_quiet    = 1'b0;
    bit        hold_output = 1'b0;

    crlf_response_line_framer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Appends a byte to the held line; false when the buffer is full.
    function automatic bit keep_byte(input logic [7:0] b);
        if (held_len < LEN_LIMIT) begin
            held_bytes[held_len] = b;
            held_len++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the line model by one received byte; the words it causes land in step_words.
    task automatic frame_rx_byte(input logic [7:0] b);
        int i;
        bit lost;
        step_words.delete();
        if (b == CH_CR) begin
            cr_seen = 1'b1;
            return;
        end
        if (b == CH_LF && cr_seen) begin
            if (held_len != 0) begin
                // A line of exactly R, D, Y is swallowed.
                if (!(held_len == 3 && held_bytes[0] == CH_R && held_bytes[1] == CH_D &&
                      held_bytes[2] == CH_Y)) begin
                    for (i = 0; i < held_len; i++) begin
                        step_words.push_back('{held_bytes[i], (i + 1 == held_len), 1'b0});
                    end
                end
                held_len = '0;
            end
        end else begin
            lost = 1'b0;
            // A CR that is not followed by LF becomes data ahead of this byte.
            if (b != CH_LF && cr_seen) begin
                if (!keep_byte(CH_CR)) lost = 1'b1;
            end
            if (!keep_byte(b)) lost = 1'b1;
            if (lost) step_words.push_back(OVERFLOW_WORD);
        end
        cr_seen = 1'b0;
    endtask

    // Offers one byte after a random gap and books what it should produce once taken.
    task automatic send_byte(input logic [7:0] b, input row_kind_e kind);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        frame_rx_byte(b);
        case (kind)
            ROW_CALC: begin
                foreach (step_words[i]) line_words_due.push_back(step_words[i]);
            end
            ROW_DROP: begin
                line_words_due.push_back(OVERFLOW_WORD);
            end
            default: begin
            end
        endcase
    endtask

    // Mostly text with a rare CR or LF inside.
    function automatic logic [7:0] rand_text_byte();
        case ($urandom_range(0, 19))
            0:       return CH_LF;
            1:       return CH_CR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One random sequence: a regular line, an RDY variant, a long line that may overflow, or noise.
    task automatic send_random_line();
        logic [7:0] seq [$];
        int         flavor;
        int         len;
        int         i;
        bit         ended;
        flavor   = $urandom_range(0, 99);
        tx_quiet = ($urandom_range(0, 3) == 0);
        ended    = ($urandom_range(0, 9) != 0);
        if (flavor < 12) begin
            seq.push_back(CH_R);
            seq.push_back(CH_D);
            seq.push_back(CH_Y);
            if ($urandom_range(0, 2) == 0) begin
                seq.push_back(rand_text_byte());
            end else if ($urandom_range(0, 3) == 0) begin
                void'(seq.pop_back());
            end
        end else if (flavor < 22) begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                seq.push_back(($urandom_range(0, 2) == 0) ?
                              (($urandom_range(0, 1) == 0) ? CH_CR : CH_LF) :
                              8'($urandom_range(0, 255)));
            end
            ended = 1'b0;
        end else begin
            len = (flavor < 26) ? $urandom_range(56, 70) : $urandom_range(0, 14);
            for (i = 0; i < len; i++) seq.push_back(rand_text_byte());
        end
        if (ended) begin
            if ($urandom_range(0, 3) == 0) seq.push_back(CH_CR);
            seq.push_back(CH_CR);
            seq.push_back(CH_LF);
        end
        foreach (seq[k]) begin
            send_byte(seq[k], ROW_CALC);
            sent_random++;
        end
    endtask

    // Result side: random stalls, one long hold, and the check of every word taken.
    initial begin
        int        stall;
        out_item_t got;
        out_item_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end
            if ($urandom_range(0, 31) == 0) rx_quiet = ~rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = '{m_tdata, m_tlast, m_tuser};
            words_seen++;
            if (line_words_due.size() == 0) begin
                flag_mismatch($sformatf("word %0d not expected: data=%02h last=%b status=%b",
                                        words_seen, got.line_byte, got.last_of_line,
                                        got.status));
            end else begin
                want = line_words_due.pop_front();
                if (got.line_byte !== want.line_byte || got.last_of_line !== want.last_of_line ||
                    got.status !== want.status) begin
                    flag_mismatch($sformatf(
                        "word %0d: data=%02h last=%b status=%b, want %02h %b %b",
                        words_seen, got.line_byte, got.last_of_line, got.status,
                        want.line_byte, want.last_of_line, want.status));
                end
            end
        end
    end

    // Input side: reset, directed rows, random lines, then drain and verdict.
    initial begin
        int  r;
        int  k;
        bit  paused;
        held_len = '0;
        cr_seen  = 1'b0;
        paused   = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < N_ROWS; r++) begin
            for (k = 0; k < DIR_ROWS[r].reps; k++) begin
                send_byte(DIR_ROWS[r].rx, DIR_ROWS[r].kind);
            end
        end

        // The result side holds off for a long stretch while lines keep coming.
        hold_output = 1'b1;
        while (sent_random < RANDOM_ITEMS) begin
            // Once, halfway, let every pending word come out before going on.
            if (!paused && sent_random >= RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                while (line_words_due.size() != 0) @(posedge aclk);
                @(posedge aclk);
                paused = 1'b1;
            end
            send_random_line();
        end

        s_tvalid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lcf_pkg.sv
src/lcf_ram.sv
src/lcf_out_buf.sv
src/crlf_response_line_framer_top.sv
tb/sv/tb_top.sv
